// ===== rtl/assert_macros.svh =====
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("assertion failed: same-cycle implication");

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("assertion failed: next-cycle implication");

`endif

// ===== rtl/lbcd_pkg.sv =====
`default_nettype none

package lbcd_pkg;

	// Request information broadcast to every cell of the chain.
	typedef struct packed {
		logic [31:0] addr;
		logic        hit;
		logic        commit;
	} lbcd_ctl_t;

	// Information handed from one cell to the next along the chain.
	typedef struct packed {
		logic        found;
		logic        taken;
		logic [31:0] addr;
	} lbcd_link_t;

	localparam int unsigned ADDR_W = 32;
	localparam int unsigned CNT_W  = 32;
	localparam int unsigned CAP_W  = 5;
	localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

endpackage

`default_nettype wire

// ===== rtl/lbcd_cell.sv =====
`default_nettype none

// One recency position of the directory: holds a slot number and the address in that slot.
module lbcd_cell #(
	parameter int IDX = 0,
	parameter int SW  = 4,
	parameter int FW  = 5
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire lbcd_pkg::lbcd_ctl_t  ctl,
	input  wire logic [FW-1:0]      filled,
	input  wire logic [FW-1:0]      pos,
	input  wire logic [SW-1:0]      prev_slot,
	input  wire logic [31:0]        prev_addr,
	input  wire lbcd_pkg::lbcd_link_t link_in,
	input  wire logic [SW-1:0]      slot_in,
	output lbcd_pkg::lbcd_link_t    link_out,
	output logic [SW-1:0]           slot_out,
	output logic [SW-1:0]           own_slot,
	output logic [31:0]             own_addr
);

	logic [SW-1:0] slot_q;
	logic [31:0]   addr_q;
	logic          in_use;
	logic          match;
	logic          sel;
	logic          shift;

	assign in_use = FW'(IDX) < filled;
	assign match  = in_use && (addr_q == ctl.addr);

	// On a hit the first matching position is chosen, on a miss the fill or victim position.
	assign sel = ctl.hit ? (match && !link_in.found) : (FW'(IDX) == pos);

	assign link_out.found = link_in.found | match;
	assign link_out.taken = link_in.taken | sel;
	assign link_out.addr  = sel ? addr_q : link_in.addr;
	assign slot_out       = sel ? slot_q : slot_in;

	// Every position up to and including the chosen one moves back by one place.
	assign shift = ctl.commit && !link_in.taken;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_q <= SW'(IDX);
		end else if (shift) begin
			slot_q <= prev_slot;
		end
	end

	always_ff @(posedge clk) begin
		if (shift) begin
			addr_q <= prev_addr;
		end
	end

	assign own_slot = slot_q;
	assign own_addr = addr_q;

endmodule

`default_nettype wire

// ===== rtl/lru_block_cache_directory.sv =====
// Channel   | Direction | Handshake                    | Payload
// s_axis    | in        | s_axis_tvalid/s_axis_tready  | tuser: action; tdata: block_addr
// m_axis    | out       | m_axis_tvalid/m_axis_tready  | tdata: result fields and counters
// cfg       | in        | cfg_valid/cfg_ready          | cfg_data: capacity
//
// Each request is captured first and then looked up and updated. The lookup and update
// are done by the compare-and-shift chain of recency cells, which settles the hit search,
// the victim choice and the shift of the recency order combinationally.
// A new request is taken once the previous result has been loaded into the output register.
// If the output is stalled, the captured request waits until the output register frees.
// Reset is asynchronous; it puts the recency order back to ascending slot numbers, clears
// the fill count and counters and sets the capacity to sixteen.
`default_nettype none

module lru_block_cache_directory #(
	parameter int MAX_ENTRIES = 16
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_axis_tvalid,
	output logic              s_axis_tready,
	input  wire logic [31:0]  s_axis_tdata,   // [31:0] block_addr
	input  wire logic [0:0]   s_axis_tuser,   // [0] action (0 read, 1 write)
	output logic              m_axis_tvalid,
	input  wire logic         m_axis_tready,
	// [0] hit, [4:1] slot, [5] evicted, [37:6] evicted_addr, [38] status,
	// [70:39] read_hits, [102:71] read_misses, [134:103] write_hits,
	// [166:135] write_misses, [167] zero
	output logic [167:0]      m_axis_tdata,
	input  wire logic         cfg_valid,
	output logic              cfg_ready,
	input  wire logic [4:0]   cfg_data        // [4:0] capacity
);

	// Slot numbers and the fill count are sized from the number of entries.
	localparam int SW = $clog2(MAX_ENTRIES);
	localparam int FW = $clog2(MAX_ENTRIES + 1);
	localparam int CW = (FW > 5) ? FW : 5;

	// Configuration register; it is always ready. Writes must arrive only when idle; the block does not enforce it.
	logic [4:0] capacity_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q <= lbcd_pkg::CAP_RESET;
		end else if (cfg_valid) begin
			capacity_q <= cfg_data;
		end
	end

	// Request capture. The block works on one request at a time.
	logic        busy_q;
	logic        action_s1;
	logic [31:0] addr_s1;
	logic        in_fire;
	logic        fire;
	logic        commit;

	assign s_axis_tready = !busy_q;
	assign in_fire       = s_axis_tvalid && s_axis_tready;
	assign fire          = busy_q && (!m_axis_tvalid || m_axis_tready);
	assign commit        = fire && (addr_s1 != 32'd0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
		end else if (in_fire) begin
			busy_q <= 1'b1;
		end else if (fire) begin
			busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			action_s1 <= s_axis_tuser[0];
			addr_s1   <= s_axis_tdata;
		end
	end

	// Effective capacity: zero acts as one, anything above the entry count is clipped.
	logic [FW-1:0] filled_q;
	logic [CW-1:0] cap_ext;
	logic [CW-1:0] cap_eff;
	logic          has_room;
	logic [FW-1:0] pos;

	assign cap_ext  = CW'(capacity_q);
	assign cap_eff  = (cap_ext == '0) ? CW'(1) :
		((cap_ext > CW'(MAX_ENTRIES)) ? CW'(MAX_ENTRIES) : cap_ext);
	assign has_room = CW'(filled_q) < cap_eff;

	// On a miss the new address goes to the first free position, or replaces the last used one.
	assign pos = has_room ? filled_q : (filled_q - FW'(1));

	// The cell chain. Position 0 is the most recent entry.
	lbcd_pkg::lbcd_ctl_t  ctl;
	lbcd_pkg::lbcd_link_t link [0:MAX_ENTRIES];
	logic [SW-1:0]        sel_slot [0:MAX_ENTRIES];
	logic [SW-1:0]        cell_slot [0:MAX_ENTRIES-1];
	logic [31:0]          cell_addr [0:MAX_ENTRIES-1];
	logic                 hit;

	assign link[0]     = '{found: 1'b0, taken: 1'b0, addr: 32'd0};
	assign sel_slot[0] = '0;
	assign hit         = link[MAX_ENTRIES].found;

	assign ctl.addr   = addr_s1;
	assign ctl.hit    = hit;
	assign ctl.commit = commit;

	for (genvar p = 0; p < MAX_ENTRIES; p++) begin : g_cell
		logic [SW-1:0] prev_slot;
		logic [31:0]   prev_addr;

		// The front cell takes the chosen slot together with the requested address.
		if (p == 0) begin : g_front
			assign prev_slot = sel_slot[MAX_ENTRIES];
			assign prev_addr = addr_s1;
		end else begin : g_rest
			assign prev_slot = cell_slot[p-1];
			assign prev_addr = cell_addr[p-1];
		end

		lbcd_cell #(
			.IDX (p),
			.SW  (SW),
			.FW  (FW)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctl       (ctl),
			.filled    (filled_q),
			.pos       (pos),
			.prev_slot (prev_slot),
			.prev_addr (prev_addr),
			.link_in   (link[p]),
			.slot_in   (sel_slot[p]),
			.link_out  (link[p+1]),
			.slot_out  (sel_slot[p+1]),
			.own_slot  (cell_slot[p]),
			.own_addr  (cell_addr[p])
		);
	end

	// Fill count grows on a miss while there is still room.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			filled_q <= '0;
		end else if (commit && !hit && has_room) begin
			filled_q <= filled_q + FW'(1);
		end
	end

	// Hit and miss counters, wrapping at 32 bits.
	logic [31:0] rd_hit_q;
	logic [31:0] rd_miss_q;
	logic [31:0] wr_hit_q;
	logic [31:0] wr_miss_q;
	logic [31:0] rd_hit_d;
	logic [31:0] rd_miss_d;
	logic [31:0] wr_hit_d;
	logic [31:0] wr_miss_d;

	always_comb begin
		rd_hit_d  = rd_hit_q;
		rd_miss_d = rd_miss_q;
		wr_hit_d  = wr_hit_q;
		wr_miss_d = wr_miss_q;
		if (commit) begin
			if (action_s1) begin
				if (hit) wr_hit_d = wr_hit_q + 32'd1;
				else     wr_miss_d = wr_miss_q + 32'd1;
			end else begin
				if (hit) rd_hit_d = rd_hit_q + 32'd1;
				else     rd_miss_d = rd_miss_q + 32'd1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_hit_q  <= '0;
			rd_miss_q <= '0;
			wr_hit_q  <= '0;
			wr_miss_q <= '0;
		end else begin
			rd_hit_q  <= rd_hit_d;
			rd_miss_q <= rd_miss_d;
			wr_hit_q  <= wr_hit_d;
			wr_miss_q <= wr_miss_d;
		end
	end

	// Result fields. A zero address reports only its status and the unchanged counters.
	logic          addr_ok;
	logic [SW+3:0] slot_wide;
	logic          res_hit;
	logic [3:0]    res_slot;
	logic          res_evicted;
	logic [31:0]   res_ev_addr;
	logic          res_status;

	assign addr_ok     = addr_s1 != 32'd0;
	assign slot_wide   = {4'b0000, sel_slot[MAX_ENTRIES]};
	assign res_hit     = addr_ok && hit;
	assign res_slot    = addr_ok ? slot_wide[3:0] : 4'd0;
	assign res_evicted = addr_ok && !hit && !has_room;
	assign res_ev_addr = res_evicted ? link[MAX_ENTRIES].addr : 32'd0;
	assign res_status  = !addr_ok;

	// Output register: it holds the result until the downstream side takes it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tvalid <= 1'b0;
		end else if (fire) begin
			m_axis_tvalid <= 1'b1;
		end else if (m_axis_tready) begin
			m_axis_tvalid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			m_axis_tdata <= {1'b0, wr_miss_d, wr_hit_d, rd_miss_d, rd_hit_d,
				res_status, res_ev_addr, res_evicted, res_slot, res_hit};
		end
	end

endmodule

`default_nettype wire

// ===== rtl/lbcd_chk.sv =====
`default_nettype none
`include "assert_macros.svh"

// Port-level checks on the cache directory.
module lbcd_chk (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_axis_tvalid,
	input  wire logic         s_axis_tready,
	input  wire logic         m_axis_tvalid,
	input  wire logic         m_axis_tready,
	input  wire logic [167:0] m_axis_tdata
);

	// A result held back by the consumer stays put.
	`ASSERT_NEXT(a_out_hold, clk, arst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))

	// Only one request is in flight, so ready drops straight after a request is taken.
	`ASSERT_NEXT(a_one_at_a_time, clk, arst_n, s_axis_tvalid && s_axis_tready, !s_axis_tready)

	// A rejected zero address carries no lookup outcome.
	`ASSERT_IMPL(a_bad_addr_quiet, clk, arst_n, m_axis_tvalid && m_axis_tdata[38], m_axis_tdata[37:0] == 38'd0)

	// A replaced address is reported only on an eviction, and an eviction is never a hit.
	`ASSERT_IMPL(a_evict_consistent, clk, arst_n, m_axis_tvalid && !m_axis_tdata[5], m_axis_tdata[37:6] == 32'd0)
	`ASSERT_IMPL(a_evict_not_hit, clk, arst_n, m_axis_tvalid && m_axis_tdata[5], !m_axis_tdata[0] && !m_axis_tdata[38])

endmodule

bind lru_block_cache_directory lbcd_chk u_lbcd_chk (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire

// ===== tb/tb_lru_block_cache_directory.sv =====
`timescale 1ns / 100ps

module tb_lru_block_cache_directory;

	// The block is built with its default number of slots, and the tracker below
	// mirrors that number.
	localparam int NUM_SLOTS = 16;

	// Request kinds as carried on s_axis_tuser.
	typedef enum logic [0:0] {
		ACT_READ  = 1'b0,
		ACT_WRITE = 1'b1
	} request_kind_e;

	// Status codes of a result.
	localparam logic STATUS_OK        = 1'b0;
	localparam logic STATUS_ZERO_ADDR = 1'b1;

	// One result as it appears on m_axis_tdata, highest bits first.
	typedef struct packed {
		logic                     pad;
		logic [lbcd_pkg::CNT_W-1:0]  write_misses;
		logic [lbcd_pkg::CNT_W-1:0]  write_hits;
		logic [lbcd_pkg::CNT_W-1:0]  read_misses;
		logic [lbcd_pkg::CNT_W-1:0]  read_hits;
		logic                     status;
		logic [lbcd_pkg::ADDR_W-1:0] evicted_addr;
		logic                     evicted;
		logic [3:0]               slot;
		logic                     hit;
	} lookup_result_t;

	// The tracker keeps its own copy of the directory: the address held in each
	// slot, the slots in recency order (most recent first), the fill count, the
	// four counters and the capacity register. Every accepted request is played
	// through it at once, and the result it predicts waits in a queue until the
	// block hands over its own result.
	class directory_tracker;
		logic [lbcd_pkg::ADDR_W-1:0] slot_addr[NUM_SLOTS];
		logic [3:0]                  lru_order[NUM_SLOTS];
		int unsigned                 filled;
		logic [lbcd_pkg::CNT_W-1:0]  rd_hits, rd_misses, wr_hits, wr_misses;
		logic [lbcd_pkg::CAP_W-1:0]  capacity_reg;
		lookup_result_t              awaited[$];
		int unsigned                 failures;

		function new();
			for (int i = 0; i < NUM_SLOTS; i++) begin
				slot_addr[i] = '0;
				lru_order[i] = 4'(i);
			end
			filled       = 0;
			rd_hits      = '0;
			rd_misses    = '0;
			wr_hits      = '0;
			wr_misses    = '0;
			capacity_reg = lbcd_pkg::CAP_RESET;
			failures     = 0;
		endfunction

		function void set_capacity(logic [lbcd_pkg::CAP_W-1:0] value);
			capacity_reg = value;
		endfunction

		function int unsigned pending();
			return awaited.size();
		endfunction

		// Bring the slot at recency position pos to the front.
		function void promote(int unsigned pos);
			logic [3:0] s;
			s = lru_order[pos];
			for (int i = pos; i > 0; i--)
				lru_order[i] = lru_order[i - 1];
			lru_order[0] = s;
		endfunction

		function void note_request(request_kind_e kind, logic [lbcd_pkg::ADDR_W-1:0] addr);
			lookup_result_t r;
			int unsigned    eff_cap;
			int unsigned    pos;
			bit             found;
			r       = '0;
			found   = 1'b0;
			pos     = 0;
			eff_cap = capacity_reg;
			if (eff_cap < 1)
				eff_cap = 1;
			if (eff_cap > NUM_SLOTS)
				eff_cap = NUM_SLOTS;
			if (addr == '0) begin
				// A zero address is refused and leaves the directory alone.
				r.status = STATUS_ZERO_ADDR;
			end else begin
				for (int i = 0; i < filled; i++) begin
					if (!found && slot_addr[lru_order[i]] == addr) begin
						found = 1'b1;
						pos   = i;
					end
				end
				if (found) begin
					r.hit  = 1'b1;
					r.slot = lru_order[pos];
					promote(pos);
					if (kind == ACT_WRITE)
						wr_hits++;
					else
						rd_hits++;
				end else begin
					if (kind == ACT_WRITE)
						wr_misses++;
					else
						rd_misses++;
					if (filled < eff_cap) begin
						pos = filled;
						filled++;
					end else begin
						// The last entry in use is the least recent, even when the
						// capacity has since been lowered below the fill count.
						pos            = filled - 1;
						r.evicted      = 1'b1;
						r.evicted_addr = slot_addr[lru_order[pos]];
					end
					r.slot                    = lru_order[pos];
					slot_addr[lru_order[pos]] = addr;
					promote(pos);
				end
			end
			r.read_hits    = rd_hits;
			r.read_misses  = rd_misses;
			r.write_hits   = wr_hits;
			r.write_misses = wr_misses;
			awaited.push_back(r);
		endfunction

		function void compare_field(string name, logic [31:0] want, logic [31:0] got);
			if (got !== want) begin
				$error("%s: expected %0h, got %0h", name, want, got);
				failures++;
			end
		endfunction

		function void check_result(logic [$bits(lookup_result_t)-1:0] data);
			lookup_result_t want, got;
			got = lookup_result_t'(data);
			if (awaited.size() == 0) begin
				$error("result: expected none, got %0h", data);
				failures++;
				return;
			end
			want = awaited.pop_front();
			compare_field("hit",          32'(want.hit),          32'(got.hit));
			compare_field("slot",         32'(want.slot),         32'(got.slot));
			compare_field("evicted",      32'(want.evicted),      32'(got.evicted));
			compare_field("evicted_addr", want.evicted_addr,      got.evicted_addr);
			compare_field("status",       32'(want.status),       32'(got.status));
			compare_field("read_hits",    want.read_hits,         got.read_hits);
			compare_field("read_misses",  want.read_misses,       got.read_misses);
			compare_field("write_hits",   want.write_hits,        got.write_hits);
			compare_field("write_misses", want.write_misses,      got.write_misses);
			compare_field("pad",          32'(want.pad),          32'(got.pad));
		endfunction
	endclass

	// Every input of the block starts at a known value.
	logic         clk           = 1'b0;
	logic         arst_n        = 1'b0;
	logic         s_axis_tvalid = 1'b0;
	logic         s_axis_tready;
	logic [31:0]  s_axis_tdata  = '0;     // [31:0] block_addr
	logic [0:0]   s_axis_tuser  = '0;     // [0] action (0 read, 1 write)
	logic         m_axis_tvalid;
	logic         m_axis_tready = 1'b0;
	// [0] hit, [4:1] slot, [5] evicted, [37:6] evicted_addr, [38] status,
	// [70:39] read_hits, [102:71] read_misses, [134:103] write_hits,
	// [166:135] write_misses, [167] zero
	logic [167:0] m_axis_tdata;
	logic         cfg_valid     = 1'b0;
	logic         cfg_ready;
	logic [4:0]   cfg_data      = '0;     // [4:0] capacity

	directory_tracker tracker;
	int unsigned      requests_taken = 0;

	lru_block_cache_directory #(
		.MAX_ENTRIES(NUM_SLOTS)
	) i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tuser (s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_data     (cfg_data)
	);

	always #5 clk = ~clk;

	// Results are taken at the rising edge, before the block's own registers
	// move on, so every check sees the values that were present at the edge.
	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready)
			tracker.check_result(m_axis_tdata);
	end

	// Offer one request from a falling edge and hold it until the block takes
	// it. The task returns on the next falling edge with tvalid still high, so a
	// request that follows straight on keeps the channel busy without a bubble.
	task automatic send_request(request_kind_e kind, logic [31:0] addr);
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= kind;
		s_axis_tdata  <= addr;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		tracker.note_request(kind, addr);
		requests_taken++;
		@(negedge clk);
	endtask

	task automatic pause_sender(int unsigned cycles);
		s_axis_tvalid <= 1'b0;
		repeat (cycles)
			@(negedge clk);
	endtask

	// Stop offering and wait until every predicted result has come back. As
	// each request gives exactly one result, the block is then idle.
	task automatic wait_until_drained();
		s_axis_tvalid <= 1'b0;
		while (tracker.pending() != 0)
			@(negedge clk);
	endtask

	task automatic write_capacity(logic [4:0] value);
		cfg_valid <= 1'b1;
		cfg_data  <= value;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		tracker.set_capacity(value);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	function automatic logic [31:0] nonzero_address();
		logic [31:0] v;
		do
			v = $urandom;
		while (v == '0);
		return v;
	endfunction

	// Random lookups for one capacity setting. Addresses come mostly from a
	// pool a little larger than the number of entries in use, so that hits,
	// fills and evictions all occur often; a few repeat a recent address to
	// provoke hits near the front of the recency order, a few are fresh random
	// values that cover every address bit, and a few are the zero address.
	// The sender works in bursts with random gaps, and some bursts have none.
	task automatic run_lookup_traffic(int unsigned count, int unsigned in_use);
		logic [31:0]   pool[$];
		logic [31:0]   recent[$];
		logic [31:0]   addr;
		request_kind_e kind;
		int unsigned   burst_left;
		int unsigned   pick;
		burst_left = 0;
		repeat (in_use + $urandom_range(1, 6))
			pool.push_back(nonzero_address());
		for (int i = 0; i < count; i++) begin
			if (burst_left == 0) begin
				burst_left = $urandom_range(1, 40);
				if ($urandom_range(0, 3) != 0)
					pause_sender($urandom_range(1, 8));
			end
			burst_left--;
			pick = $urandom_range(0, 99);
			if (pick < 5)
				addr = '0;
			else if (pick < 30 && recent.size() != 0)
				addr = recent[$urandom_range(0, recent.size() - 1)];
			else if (pick < 90)
				addr = pool[$urandom_range(0, pool.size() - 1)];
			else
				addr = nonzero_address();
			kind = request_kind_e'($urandom_range(0, 1));
			send_request(kind, addr);
			recent.push_back(addr);
			if (recent.size() > 4)
				void'(recent.pop_front());
		end
	endtask

	// Receiver: ready follows stretches of random length, each with a pattern
	// of its own (always ready, mostly ready, a fixed rhythm, or a coin toss).
	// Twice during the run it holds ready low for a long stretch while the
	// sender goes on, so that the block fills up and must stall its input.
	initial begin
		int unsigned stretch;
		int unsigned pattern;
		int unsigned hold_offs;
		hold_offs = 0;
		@(posedge arst_n);
		forever begin
			if (hold_offs < 2 && requests_taken >= 400 + 800 * hold_offs) begin
				repeat (80) begin
					@(negedge clk);
					m_axis_tready <= 1'b0;
				end
				hold_offs++;
			end else begin
				stretch = $urandom_range(10, 150);
				pattern = $urandom_range(0, 3);
				for (int c = 0; c < stretch; c++) begin
					@(negedge clk);
					case (pattern)
						0: begin
							m_axis_tready <= 1'b1;
						end
						1: begin
							m_axis_tready <= ($urandom_range(0, 3) != 0);
						end
						2: begin
							m_axis_tready <= (c % 5 != 0) && (c % 7 != 3);
						end
						default: begin
							m_axis_tready <= 1'($urandom_range(0, 1));
						end
					endcase
				end
			end
		end
	end

	// Main sequence.
	initial begin
		logic [4:0]  early_caps[6];
		logic [4:0]  late_caps[7];
		int unsigned in_use;
		early_caps = '{5'd1, 5'd2, 5'd3, 5'd5, 5'd8, 5'd12};
		late_caps  = '{5'd31, 5'd17, 5'd1, 5'd0, 5'd16, 5'd4, 5'd16};
		tracker = new();
		repeat (10)
			@(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// A capacity of zero behaves as one: each new address evicts the last.
		// The zero address is refused for both kinds of request.
		write_capacity(5'd0);
		send_request(ACT_READ,  32'h0000_0000);
		send_request(ACT_WRITE, 32'h0000_0000);
		send_request(ACT_READ,  32'hFFFF_FFFF);
		send_request(ACT_WRITE, 32'hFFFF_FFFF);
		send_request(ACT_READ,  32'h0000_0001);
		send_request(ACT_WRITE, 32'h0000_0001);
		send_request(ACT_READ,  32'hFFFF_FFFF);
		wait_until_drained();

		// Small capacities, raised step by step so that each one fills first.
		foreach (early_caps[k]) begin
			write_capacity(early_caps[k]);
			run_lookup_traffic(150, early_caps[k]);
			wait_until_drained();
		end

		// Full capacity: fill the last free slots, then evict, then hit an
		// entry far back in the recency order.
		write_capacity(5'd16);
		send_request(ACT_WRITE, 32'h8000_0000);
		send_request(ACT_READ,  32'h4000_0000);
		send_request(ACT_WRITE, 32'h0000_0002);
		send_request(ACT_READ,  32'h5555_5555);
		send_request(ACT_WRITE, 32'hAAAA_AAAA);
		send_request(ACT_READ,  32'hFFFF_FFFE);
		send_request(ACT_WRITE, 32'h8000_0000);
		send_request(ACT_READ,  32'h0000_0000);
		wait_until_drained();

		// Capacities above the slot count act as the slot count; lowering the
		// capacity below the fill count keeps every filled entry in use.
		foreach (late_caps[k]) begin
			write_capacity(late_caps[k]);
			in_use = NUM_SLOTS;
			run_lookup_traffic(150, in_use);
			wait_until_drained();
		end

		// Let any stray result show itself before the verdict.
		repeat (10)
			@(negedge clk);
		if (tracker.failures == 0 && tracker.pending() == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

	// Overall time limit, far beyond the slowest correct run.
	initial begin
		#5_000_000;
		$display("simulation failed");
		$finish;
	end

endmodule
